// ===== sv/base_pair_helix_splitter_defines.svh =====
// Assertion macros used by the helix splitter sequencer.
`ifndef BASE_PAIR_HELIX_SPLITTER_DEFINES_SVH
`define BASE_PAIR_HELIX_SPLITTER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, muted while i_rst_n is low.
`define BPHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, muted while i_rst_n is low.
`define BPHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bphs_pkg.sv =====
// Package: sizes, codes and the result record of the helix splitter.
`default_nettype none

package bphs_pkg;

    localparam int MAX_LEN = 1024;                 // stack depth in entries
    localparam int POS_W   = 11;                   // position / partner width
    localparam int SP_W    = $clog2(MAX_LEN + 1);  // stack pointer, holds MAX_LEN
    localparam int ADDR_W  = $clog2(MAX_LEN);      // stack RAM address
    localparam int ENT_W   = 1 + 2 * POS_W;        // face flag + two 11-bit fields

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NO_PARTNER = 2'd1;
    localparam logic [1:0] STAT_MISMATCH   = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] left_pos;
        logic [POS_W-1:0] right_pos;
        logic [POS_W-1:0] helix_index;
        logic [1:0]       status;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/bphs_if.sv =====
// Handshake interfaces for the input and result channels.
`default_nettype none

interface bphs_in_if
    import bphs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] partner;
    logic             end_of_structure;

    modport source (output valid, partner, end_of_structure, input ready);
    modport sink   (input valid, partner, end_of_structure, output ready);
endinterface

interface bphs_out_if
    import bphs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [POS_W-1:0] left_pos;
    logic [POS_W-1:0] right_pos;
    logic [POS_W-1:0] helix_index;
    logic [1:0]       status;
    logic             last;

    modport source (output valid, kind, left_pos, right_pos, helix_index, status, last,
                    input ready);
    modport sink   (input valid, kind, left_pos, right_pos, helix_index, status, last,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/bphs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bphs_seq.sv =====
// Sequencer: stack pops one entry a cycle through the RAM read port.
`default_nettype none

`include "base_pair_helix_splitter_defines.svh"

module bphs_seq
    import bphs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input item
    input  wire logic              i_valid,
    input  wire logic [POS_W-1:0]  i_partner,
    input  wire logic              i_eos,
    output logic                   o_ready,
    // result towards the output register
    output logic                   o_res_valid,
    output t_result                o_res,
    input  wire logic              i_res_ready,
    // stack RAM
    output logic                   o_we,
    output logic [ADDR_W-1:0]      o_waddr,
    output logic [ENT_W-1:0]       o_wdata,
    output logic                   o_re,
    output logic [ADDR_W-1:0]      o_raddr,
    input  wire logic [ENT_W-1:0]  i_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PAIR,
        S_STAT
    } t_state;

    t_state           r_state,   n_state;
    logic [SP_W-1:0]  r_sp,      n_sp;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [POS_W-1:0] r_helix,   n_helix;
    logic [POS_W-1:0] r_opened,  n_opened;
    logic [POS_W-1:0] r_matched, n_matched;
    logic             r_err,     n_err;
    logic             r_eos,     n_eos;
    logic [1:0]       r_faces,   n_faces;   // saturates at 2: only 0 and >1 matter
    logic [POS_W-1:0] r_deep,    n_deep;
    logic [POS_W-1:0] r_left,    n_left;

    logic [POS_W-1:0] pos_inc;
    logic [SP_W-1:0]  sp_dec;
    logic             ent_face;
    logic [POS_W-1:0] ent_hi;
    logic [POS_W-1:0] ent_lo;
    logic [POS_W-1:0] deep_fin;

    assign pos_inc  = r_pos + 1'b1;
    assign sp_dec   = r_sp - 1'b1;
    assign ent_face = i_rdata[ENT_W-1];
    assign ent_hi   = i_rdata[2*POS_W-1:POS_W];
    assign ent_lo   = i_rdata[POS_W-1:0];
    assign deep_fin = (r_faces > 2'd1 && r_deep != POS_MAX) ? r_deep + 1'b1 : r_deep;

    assign o_raddr = sp_dec[ADDR_W-1:0];
    assign o_waddr = r_sp[ADDR_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_sp      = r_sp;
        n_pos     = r_pos;
        n_helix   = r_helix;
        n_opened  = r_opened;
        n_matched = r_matched;
        n_err     = r_err;
        n_eos     = r_eos;
        n_faces   = r_faces;
        n_deep    = r_deep;
        n_left    = r_left;
        o_we        = 1'b0;
        o_wdata     = '0;
        o_re        = 1'b0;
        o_ready     = (r_state == S_IDLE);
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pos   = pos_inc;
                    n_eos   = i_eos;
                    n_state = i_eos ? S_STAT : S_IDLE;
                    if (!r_err && i_partner != '0) begin
                        if (i_partner > pos_inc) begin
                            // opening base
                            n_opened = r_opened + 1'b1;
                            if (r_sp != SP_W'(MAX_LEN)) begin
                                o_we    = 1'b1;
                                o_wdata = {1'b0, pos_inc, i_partner};
                                n_sp    = r_sp + 1'b1;
                            end
                        end else begin
                            // closing base: start popping
                            n_faces = 2'd0;
                            n_deep  = POS_W'(1);
                            if (r_sp == '0) begin
                                n_err = 1'b1;
                            end else begin
                                o_re    = 1'b1;
                                n_sp    = sp_dec;
                                n_state = S_SCAN;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (!ent_face && ent_lo == r_pos) begin
                    // partner found: leave a face marker in the freed slot
                    n_matched = r_matched + 1'b1;
                    o_we      = 1'b1;
                    o_wdata   = {1'b1, deep_fin, {POS_W{1'b0}}};
                    n_sp      = r_sp + 1'b1;
                    n_left    = ent_hi;
                    if (r_faces == 2'd0) begin
                        n_helix = r_helix + 1'b1;
                    end
                    n_state = S_PAIR;
                end else begin
                    if (ent_face) begin
                        if (r_faces != 2'd2) begin
                            n_faces = r_faces + 1'b1;
                        end
                        if (ent_hi > r_deep) begin
                            n_deep = ent_hi;
                        end
                    end
                    if (r_sp == '0) begin
                        n_err   = 1'b1;
                        n_state = r_eos ? S_STAT : S_IDLE;
                    end else begin
                        o_re = 1'b1;
                        n_sp = sp_dec;
                    end
                end
            end
            S_PAIR: begin
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_PAIR;
                o_res.left_pos    = r_left;
                o_res.right_pos   = r_pos;
                o_res.helix_index = r_helix;
                o_res.status      = STAT_OK;
                o_res.last        = !r_eos;
                if (i_res_ready) begin
                    n_state = r_eos ? S_STAT : S_IDLE;
                end
            end
            S_STAT: begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_STATUS;
                o_res.last  = 1'b1;
                if (r_err) begin
                    o_res.status = STAT_NO_PARTNER;
                end else if (r_opened != r_matched) begin
                    o_res.status = STAT_MISMATCH;
                end else begin
                    o_res.status = STAT_OK;
                end
                if (i_res_ready) begin
                    n_state   = S_IDLE;
                    n_sp      = '0;
                    n_pos     = '0;
                    n_helix   = '0;
                    n_opened  = '0;
                    n_matched = '0;
                    n_err     = 1'b0;
                    n_eos     = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '0;
            r_pos     <= '0;
            r_helix   <= '0;
            r_opened  <= '0;
            r_matched <= '0;
            r_err     <= 1'b0;
            r_eos     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_pos     <= n_pos;
            r_helix   <= n_helix;
            r_opened  <= n_opened;
            r_matched <= n_matched;
            r_err     <= n_err;
            r_eos     <= n_eos;
        end
        r_faces <= n_faces;
        r_deep  <= n_deep;
        r_left  <= n_left;
    end

    `BPHS_ASSERT_NOW(a_sp_range, 1'b1, r_sp <= SP_W'(MAX_LEN), "stack pointer past depth")
    `BPHS_ASSERT_NOW(a_pop_nonempty, o_re, r_sp != '0, "pop from empty stack")
    `BPHS_ASSERT_NOW(a_face_fits, (r_state == S_SCAN && o_we), r_sp != SP_W'(MAX_LEN),
        "face marker pushed onto full stack")
    `BPHS_ASSERT_NOW(a_pair_no_err, r_state == S_PAIR, !r_err, "pair after lost partner")
    `BPHS_ASSERT_NEXT(a_stat_clears, (r_state == S_STAT && i_res_ready),
        (r_sp == '0 && r_pos == '0 && !r_err), "state not cleared after status")

endmodule

`default_nettype wire

// ===== sv/base_pair_helix_splitter.sv =====
// Top level: helix splitter with stack RAM, sequencer and output register.
//
//   channel    dir  fields                                               transfer
//   i_item     in   partner[10:0], end_of_structure                      valid & ready
//   o_result   out  kind, left_pos, right_pos, helix_index, status, last valid & ready
//
// Timing: an opening or unpaired base needs no further state. A closing
//   base pops stack entries one per cycle, paced by the single read port
//   of the stack RAM, then hands over the pair. An end marker adds the
//   status transfer.
// Reset: synchronous, active low; the position, helix and pair counters and the
//   stack pointer clear; stack contents stay and are never read before written.
// Stalls: results wait in a one-deep output register; the sequencer holds
//   in its emit states while that register is full and not drained.
`default_nettype none

module base_pair_helix_splitter
    import bphs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bphs_in_if.sink     i_item,
    bphs_out_if.source  o_result
);

    logic              seq_res_valid;
    t_result           seq_res;
    logic              ld_ready;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    logic              r_o_valid, n_o_valid;
    t_result           r_o_res,   n_o_res;

    // pair stack: {face, position or depth, partner}
    bphs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LEN)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bphs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_item.valid),
        .i_partner   (i_item.partner),
        .i_eos       (i_item.end_of_structure),
        .o_ready     (i_item.ready),
        .o_res_valid (seq_res_valid),
        .o_res       (seq_res),
        .i_res_ready (ld_ready),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    // Output register: loads when empty or draining in the same cycle.
    assign ld_ready = !r_o_valid || o_result.ready;

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_res   = r_o_res;
        if (seq_res_valid && ld_ready) begin
            n_o_valid = 1'b1;
            n_o_res   = seq_res;
        end else if (o_result.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
        r_o_res <= n_o_res;
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.kind        = r_o_res.kind;
    assign o_result.left_pos    = r_o_res.left_pos;
    assign o_result.right_pos   = r_o_res.right_pos;
    assign o_result.helix_index = r_o_res.helix_index;
    assign o_result.status      = r_o_res.status;
    assign o_result.last        = r_o_res.last;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the base-pair helix splitter: directed, stress and random structures.

module testbench;
    import bphs_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;  // far above the slowest legal run
    localparam int RANDOM_ITEMS = 400;
    localparam int NEST_SPAN    = 128;        // deep nest covers positions 1 .. NEST_SPAN-1
    localparam int DRAIN_CYCLES = 50;
    localparam int POS_SPAN     = 1 << POS_W;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} t_rdy_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bphs_in_if  item_ch ();
    bphs_out_if result_ch ();

    base_pair_helix_splitter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: stack of open bases and face markers, plus counters
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] open_stack [MAX_LEN];
    int               stack_depth;
    logic [POS_W-1:0] base_pos;
    logic [POS_W-1:0] helix_no;
    logic [POS_W-1:0] opened_cnt;
    logic [POS_W-1:0] closed_cnt;
    logic             lost_partner;   // sticky until the end marker

    t_result          pending_results [$];  // expected results, oldest first
    logic [POS_W-1:0] partner_plan [$];     // partners of the structure about to be sent

    int fail_count;
    int cycle_count;
    int items_sent;
    int structures_sent;
    int pairs_checked;
    int status_tally [3];
    int burst_left;
    bit no_gaps;

    function automatic void clear_prediction();
        stack_depth  = 0;
        base_pos     = '0;
        helix_no     = '0;
        opened_cnt   = '0;
        closed_cnt   = '0;
        lost_partner = 1'b0;
    endfunction

    // Works out the results caused by one accepted base.
    function automatic void predict_base(logic [POS_W-1:0] p, logic eos);
        logic [ENT_W-1:0] e;
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] deepest;
        int               faces;
        bit               found;
        t_result          r;

        base_pos = base_pos + 1'b1;
        items_sent++;
        if (!lost_partner && p != '0) begin
            if (p > base_pos) begin
                // opening base; counted even when the stack has no room
                opened_cnt = opened_cnt + 1'b1;
                if (stack_depth < MAX_LEN) begin
                    open_stack[stack_depth] = {1'b0, base_pos, p};
                    stack_depth++;
                end
            end else begin
                // closing base (self pair included): unwind to its partner
                faces   = 0;
                deepest = POS_W'(1);
                found   = 1'b0;
                left    = '0;
                while (stack_depth > 0 && !found) begin
                    stack_depth--;
                    e = open_stack[stack_depth];
                    if (e[ENT_W-1]) begin
                        faces++;
                        if (e[2*POS_W-1:POS_W] > deepest) deepest = e[2*POS_W-1:POS_W];
                    end else if (e[POS_W-1:0] == base_pos) begin
                        found = 1'b1;
                        left  = e[2*POS_W-1:POS_W];
                    end
                end
                if (found) begin
                    closed_cnt = closed_cnt + 1'b1;
                    if (faces > 1 && deepest != POS_MAX) deepest = deepest + 1'b1;
                    open_stack[stack_depth] = {1'b1, deepest, {POS_W{1'b0}}};
                    stack_depth++;
                    // new helix only when nothing lay between the two bases
                    if (faces == 0) helix_no = helix_no + 1'b1;
                    r = '{kind: KIND_PAIR, left_pos: left, right_pos: base_pos,
                          helix_index: helix_no, status: STAT_OK, last: !eos};
                    pending_results.push_back(r);
                end else begin
                    lost_partner = 1'b1;
                end
            end
        end
        if (eos) begin
            r = '{kind: KIND_STATUS, left_pos: '0, right_pos: '0, helix_index: '0,
                  status: lost_partner ? STAT_NO_PARTNER :
                          (opened_cnt != closed_cnt ? STAT_MISMATCH : STAT_OK),
                  last: 1'b1};
            pending_results.push_back(r);
            structures_sent++;
            clear_prediction();
        end
    endfunction

    function automatic void compare_field(string name, logic [POS_W-1:0] want,
                                          logic [POS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result with nothing pending: kind %0d left %0d right %0d status %0d",
                   result_ch.kind, result_ch.left_pos, result_ch.right_pos, result_ch.status);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind",        want.kind,        result_ch.kind);
        compare_field("left_pos",    want.left_pos,    result_ch.left_pos);
        compare_field("right_pos",   want.right_pos,   result_ch.right_pos);
        compare_field("helix_index", want.helix_index, result_ch.helix_index);
        compare_field("status",      want.status,      result_ch.status);
        compare_field("last",        want.last,        result_ch.last);
        if (want.kind == KIND_PAIR) pairs_checked++;
        else status_tally[want.status]++;
    endfunction

    // Both channels are sampled at the rising edge; prediction runs first.
    always @(posedge i_clk) begin
        if (i_rst_n && item_ch.valid && item_ch.ready)
            predict_base(item_ch.partner, item_ch.end_of_structure);
        if (i_rst_n && result_ch.valid && result_ch.ready)
            check_result();
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Result side back-pressure: segments of always-ready, coin-flip and
    // fixed on/off patterns, so stalls land on every phase of a pop run.
    initial begin : result_stall
        t_rdy_mode stall_mode;
        int        seg_left;
        int        phase;
        int        on_len;
        int        off_len;
        logic      rdy;
        result_ch.ready = 1'b0;
        seg_left = 0;
        stall_mode = RDY_ALWAYS;
        phase = 0;
        on_len = 1;
        off_len = 1;
        forever begin
            @(negedge i_clk);
            if (seg_left == 0) begin
                stall_mode = t_rdy_mode'($urandom_range(0, 2));
                seg_left   = $urandom_range(50, 400);
                phase      = 0;
                on_len     = $urandom_range(1, 6);
                off_len    = $urandom_range(1, 8);
            end
            seg_left--;
            case (stall_mode)
                RDY_ALWAYS: rdy = 1'b1;
                RDY_RANDOM: rdy = ($urandom_range(0, 99) < 65);
                default: begin
                    rdy   = (phase < on_len);
                    phase = (phase + 1) % (on_len + off_len);
                end
            endcase
            result_ch.ready <= rdy;
        end
    end

    // One transfer on the input channel; bursts with random gaps between them.
    task automatic send_item(logic [POS_W-1:0] p, logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                item_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        item_ch.valid            <= 1'b1;
        item_ch.partner          <= p;
        item_ch.end_of_structure <= eos;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // Sends the planned structure with the end marker on its last base.
    task automatic send_structure();
        for (int i = 0; i < partner_plan.size(); i++)
            send_item(partner_plan[i], i == partner_plan.size() - 1);
    endtask

    // Bracket notation to partners. '(' ')' and '[' ']' pair independently,
    // so mixing them gives crossing pairs. An opener left unclosed points
    // one past the end, so it counts as opened but never matches.
    function automatic void plan_from_brackets(string s);
        int round_open [$];
        int square_open [$];
        int j;
        partner_plan.delete();
        for (int i = 0; i < s.len(); i++) partner_plan.push_back('0);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == "(") round_open.push_back(i + 1);
            else if (s[i] == "[") square_open.push_back(i + 1);
            else if (s[i] == ")" && round_open.size() > 0) begin
                j = round_open.pop_back();
                partner_plan[i]     = POS_W'(j);
                partner_plan[j - 1] = POS_W'(i + 1);
            end else if (s[i] == "]" && square_open.size() > 0) begin
                j = square_open.pop_back();
                partner_plan[i]     = POS_W'(j);
                partner_plan[j - 1] = POS_W'(i + 1);
            end
        end
        foreach (round_open[k])  partner_plan[round_open[k] - 1]  = POS_W'(s.len() + 1);
        foreach (square_open[k]) partner_plan[square_open[k] - 1] = POS_W'(s.len() + 1);
    endfunction

    // Random balanced structure; with knots, square brackets cross the round ones.
    function automatic string random_brackets(int len, bit knots);
        string s;
        int    round_open;
        int    square_open;
        int    r;
        int    remaining;
        s = "";
        round_open  = 0;
        square_open = 0;
        for (int i = 0; i < len; i++) begin
            remaining = len - i;
            r = $urandom_range(0, 99);
            if (round_open + square_open >= remaining) r = 50;  // must close now
            if (r < 30 && remaining > round_open + square_open + 1) begin
                s = {s, "("};
                round_open++;
            end else if (r < 36 && knots && remaining > round_open + square_open + 1) begin
                s = {s, "["};
                square_open++;
            end else if (r < 70 && round_open + square_open > 0) begin
                if (square_open > 0 && (round_open == 0 || $urandom_range(0, 1))) begin
                    s = {s, "]"};
                    square_open--;
                end else begin
                    s = {s, ")"};
                    round_open--;
                end
            end else begin
                s = {s, "."};
            end
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_basics();
        plan_from_brackets(".");       // lone unpaired base: status only
        send_structure();
        plan_from_brackets("()");      // pair and status from the same transfer
        send_structure();
        plan_from_brackets("(()())");  // multiloop: two helices, outer pair keeps index
        send_structure();
        plan_from_brackets("((..))");  // stacked pairs share one helix
        send_structure();
        partner_plan = {11'd1, 11'd0};  // self pair on an empty stack: partner lost
        send_structure();
        plan_from_brackets("([)]");    // crossing pairs lose the second partner
        send_structure();
        plan_from_brackets("((");      // never closed: opened and matched differ
        send_structure();
        partner_plan = {11'd2047, 11'd1024, 11'd0};  // extreme partner values
        send_structure();
    endtask

    task automatic test_stack_overflow();
        // one opener too many is counted but dropped; the first close finds
        // the last base that fitted, the second finds no partner and unwinds
        // the whole stack
        partner_plan.delete();
        repeat (MAX_LEN + 1) partner_plan.push_back(POS_W'(MAX_LEN + 2));
        partner_plan.push_back(11'd1);
        partner_plan.push_back(11'd2);
        partner_plan.push_back(11'd0);
        send_structure();
    endtask

    task automatic test_deep_nest();
        // fully nested pairs, one unpaired base in the middle, end on the last close
        partner_plan.delete();
        for (int i = 1; i < NEST_SPAN; i++)
            partner_plan.push_back(i == NEST_SPAN / 2 ? '0 : POS_W'(NEST_SPAN - i));
        send_structure();
    endtask

    task automatic test_random_structures();
        int sent;
        int len;
        int k;
        bit knots;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(1, 40);
            knots   = ($urandom_range(0, 3) == 0);
            no_gaps = ($urandom_range(0, 3) == 0);
            plan_from_brackets(random_brackets(len, knots));
            // a fifth of the structures get a few damaged partners
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    k = $urandom_range(0, len - 1);
                    case ($urandom_range(0, 3))
                        0:       partner_plan[k] = '0;
                        1:       partner_plan[k] = POS_W'(k + 1);
                        2:       partner_plan[k] = POS_W'($urandom_range(0, POS_SPAN - 1));
                        default: partner_plan[k] = partner_plan[k] + 1'b1;
                    endcase
                end
            end
            send_structure();
            sent += len;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n                  = 1'b0;
        item_ch.valid            = 1'b0;
        item_ch.partner          = '0;
        item_ch.end_of_structure = 1'b0;
        burst_left               = 0;
        no_gaps                  = 1'b0;
        clear_prediction();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_stack_overflow();
        test_deep_nest();
        test_random_structures();

        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bases in %0d structures, %0d pairs checked",
                 items_sent, structures_sent, pairs_checked);
        $display("end status seen: ok %0d, partner lost %0d, count mismatch %0d",
                 status_tally[STAT_OK], status_tally[STAT_NO_PARTNER],
                 status_tally[STAT_MISMATCH]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
